/* rtl/core/fflsa_pkg.sv */
// Shared types and codes for the free-list slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package fflsa_pkg;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_RANGE    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_HANDLE = 2'd2;

	localparam logic [1:0] CFG_SLOT_COUNT  = 2'd0;
	localparam logic [1:0] CFG_SLOT_STRIDE = 2'd1;
	localparam logic [1:0] CFG_CPU_BASE    = 2'd2;
	localparam logic [1:0] CFG_GPU_BASE    = 2'd3;

	localparam int IndexW  = 10;
	localparam int CountW  = 11;
	localparam int StrideW = 13;
	localparam int AddrW   = 64;
	localparam int ProdW   = CountW + StrideW;

	// Control carried with an item from the accept stage to the address stages.
	typedef struct packed {
		status_t status;
		logic    use_addr;
		logic    show_grant;
		logic    from_mem;
	} ctl_t;

endpackage
`default_nettype wire

/* rtl/core/fflsa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fflsa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/fflsa_ctrl.sv */
// Accept stage: fresh counter, freed-index FIFO pointers and the FIFO memory.
`timescale 1ns / 1ps
`default_nettype none
module fflsa_ctrl import fflsa_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CountW-1:0] slot_count,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [15:0]       s_tdata,
	input  wire logic [1:0]        s_tuser,
	input  wire logic              s1_ready,
	output logic                   s1_valid,
	output ctl_t                   s1_ctl,
	output logic      [CountW-1:0] s1_index,
	output logic      [IndexW-1:0] mem_rdata
);

	localparam int PtrW = $clog2(MAX_SLOTS);
	localparam int OccW = $clog2(MAX_SLOTS + 1);

	logic [CountW-1:0] fresh_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [PtrW-1:0]   wr_ptr_q;
	logic [OccW-1:0]   occ_q;
	logic              s1_valid_q;
	ctl_t              ctl_s1;
	logic [CountW-1:0] index_s1;

	logic              accept;
	logic [IndexW-1:0] idx;
	logic [CountW-1:0] live_cnt;
	logic              fresh_ok;
	logic              fifo_full;
	logic              take_fresh;
	logic              pop;
	logic              push;
	ctl_t              ctl_d;
	logic [CountW-1:0] index_d;

	assign s_tready = !s1_valid_q || s1_ready;
	assign accept   = s_tvalid && s_tready;
	assign idx      = s_tdata[IndexW-1:0];

	// The usable count never exceeds the FIFO capacity.
	assign live_cnt  = (32'(slot_count) > MAX_SLOTS) ? CountW'(MAX_SLOTS) : slot_count;
	assign fresh_ok  = fresh_q < live_cnt;
	assign fifo_full = occ_q == OccW'(MAX_SLOTS);

	always_comb begin
		ctl_d      = '{status: ST_OK, use_addr: 1'b0, show_grant: 1'b0, from_mem: 1'b0};
		index_d    = '0;
		take_fresh = 1'b0;
		pop        = 1'b0;
		push       = 1'b0;
		case (s_tuser)
			KIND_ALLOC: begin
				if (fresh_ok) begin
					take_fresh       = 1'b1;
					index_d          = fresh_q;
					ctl_d.use_addr   = 1'b1;
					ctl_d.show_grant = 1'b1;
				end else if (occ_q != '0) begin
					pop              = 1'b1;
					ctl_d.use_addr   = 1'b1;
					ctl_d.show_grant = 1'b1;
					ctl_d.from_mem   = 1'b1;
				end else begin
					ctl_d.status = ST_EMPTY;
				end
			end
			KIND_FREE: begin
				if ({1'b0, idx} >= live_cnt) begin
					ctl_d.status = ST_RANGE;
				end else if (fifo_full) begin
					ctl_d.status = ST_OVERFLOW;
				end else begin
					push = 1'b1;
				end
			end
			KIND_HANDLE: begin
				ctl_d.use_addr = 1'b1;
				index_d        = {1'b0, idx};
			end
			default: begin
				ctl_d.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q    <= '0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			occ_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (accept) begin
				if (take_fresh) begin
					fresh_q <= fresh_q + 1'b1;
				end
				if (pop) begin
					rd_ptr_q <= (rd_ptr_q == PtrW'(MAX_SLOTS - 1)) ? '0 : rd_ptr_q + 1'b1;
					occ_q    <= occ_q - 1'b1;
				end
				if (push) begin
					wr_ptr_q <= (wr_ptr_q == PtrW'(MAX_SLOTS - 1)) ? '0 : wr_ptr_q + 1'b1;
					occ_q    <= occ_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1   <= ctl_d;
			index_s1 <= index_d;
		end
	end

	// A pop reads the entry at the read pointer; its data is valid while the item sits in s1,
	// because no other read is issued until the item moves on.
	fflsa_ram #(
		.WIDTH(IndexW),
		.DEPTH(MAX_SLOTS)
	) u_freed_ram (
		.clk    (clk),
		.we     (accept && push),
		.waddr  (wr_ptr_q),
		.wdata  (idx),
		.re     (accept && pop),
		.raddr  (rd_ptr_q),
		.rdata_q(mem_rdata)
	);

	assign s1_valid = s1_valid_q;
	assign s1_ctl   = ctl_s1;
	assign s1_index = index_s1;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OccW'(MAX_SLOTS))
		else $error("free list occupancy above capacity");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + 1'b1)
			|| (occ_q == $past(occ_q) - 1'b1))
		else $error("free list occupancy moved by more than one");

	a_fresh_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> fresh_q >= $past(fresh_q))
		else $error("fresh counter went backwards");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_ready) |=> s1_valid_q && $stable(index_s1) && $stable(mem_rdata))
		else $error("stalled item in s1 changed");

endmodule
`default_nettype wire

/* rtl/core/fflsa_addr.sv */
// Address stages: index times stride, base add, and the output register.
`timescale 1ns / 1ps
`default_nettype none
module fflsa_addr import fflsa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [StrideW-1:0] slot_stride,
	input  wire logic [AddrW-1:0]   cpu_base,
	input  wire logic [AddrW-1:0]   gpu_base,
	input  wire logic               s1_valid,
	input  wire ctl_t               s1_ctl,
	input  wire logic [CountW-1:0]  s1_index,
	input  wire logic [IndexW-1:0]  mem_rdata,
	output logic                    s1_ready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [143:0]       m_tdata,
	output logic      [1:0]         m_tuser
);

	logic              valid_s2;
	status_t           status_s2;
	logic              use_addr_s2;
	logic [IndexW-1:0] granted_s2;
	logic [ProdW-1:0]  prod_s2;

	logic              out_valid_q;
	status_t           status_q;
	logic [IndexW-1:0] granted_q;
	logic [AddrW-1:0]  cpu_q;
	logic [AddrW-1:0]  gpu_q;

	logic              adv_out;
	logic [CountW-1:0] idx_s1;

	assign adv_out  = !out_valid_q || m_tready;
	assign s1_ready = !valid_s2 || adv_out;
	assign idx_s1   = s1_ctl.from_mem ? {1'b0, mem_rdata} : s1_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s2 <= s1_valid;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && s1_valid) begin
			status_s2   <= s1_ctl.status;
			use_addr_s2 <= s1_ctl.use_addr;
			granted_s2  <= s1_ctl.show_grant ? idx_s1[IndexW-1:0] : '0;
			prod_s2     <= ProdW'(idx_s1) * ProdW'(slot_stride);
		end
		if (adv_out && valid_s2) begin
			status_q  <= status_s2;
			granted_q <= granted_s2;
			cpu_q     <= use_addr_s2 ? cpu_base + AddrW'(prod_s2) : '0;
			gpu_q     <= use_addr_s2 ? gpu_base + AddrW'(prod_s2) : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {6'd0, gpu_q, cpu_q, granted_q};

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && granted_q != '0) |-> status_q == ST_OK)
		else $error("grant shown with an error status");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (cpu_q == '0) && (gpu_q == '0))
		else $error("addresses shown with an error status");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv_out) |=> valid_s2 && $stable(prod_s2))
		else $error("stalled item in s2 was lost");

endmodule
`default_nettype wire

/* rtl/core/fifo_free_list_slot_allocator.sv */
// Top level of the FIFO free-list slot allocator.
//
// Input stream (s_*): one beat is one command. tuser holds the kind (allocate, free,
// handle); tdata holds the slot index. Output stream (m_*): one result beat per command,
// tuser holds the status, tdata holds granted index, CPU address and GPU address.
// The cfg channel writes slot_count, slot_stride, cpu_base and gpu_base by index; it is
// always ready and is meant to be used only while no command is in flight.
//
// An accepted input beat passes through the registered stages in order to a valid result beat:
// the accept stage issues the free-list memory read, the next stage forms
// index times stride, the last adds the bases into the output register.
// Throughput is one command per cycle when the receiver does not stall; the free-list
// memory is read or written at most once per command, and its read data is held while
// a command waits downstream. When the receiver stalls, the three stages fill and
// s_tready drops; nothing is lost. Reset empties the pipeline, restores the register
// defaults and makes the full set of indices 0 to slot_count-1 available again, handed
// out in ascending order first. The freed-index memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module fifo_free_list_slot_allocator import fflsa_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,   // [9:0] slot_index
	input  wire logic [1:0]   s_tuser,   // [1:0] kind
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [143:0] m_tdata,   // [9:0] granted_index, [73:10] cpu_address,
	                                     // [137:74] gpu_address
	output logic      [1:0]   m_tuser,   // [1:0] status
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);

	logic [CountW-1:0]  slot_count_q;
	logic [StrideW-1:0] slot_stride_q;
	logic [AddrW-1:0]   cpu_base_q;
	logic [AddrW-1:0]   gpu_base_q;

	logic              s1_valid;
	logic              s1_ready;
	ctl_t              s1_ctl;
	logic [CountW-1:0] s1_index;
	logic [IndexW-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q  <= CountW'(1024);
			slot_stride_q <= StrideW'(32);
			cpu_base_q    <= '0;
			gpu_base_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLOT_COUNT:  slot_count_q  <= cfg_data[CountW-1:0];
				CFG_SLOT_STRIDE: slot_stride_q <= cfg_data[StrideW-1:0];
				CFG_CPU_BASE:    cpu_base_q    <= cfg_data;
				CFG_GPU_BASE:    gpu_base_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fflsa_ctrl #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.slot_count(slot_count_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s1_ready  (s1_ready),
		.s1_valid  (s1_valid),
		.s1_ctl    (s1_ctl),
		.s1_index  (s1_index),
		.mem_rdata (mem_rdata)
	);

	fflsa_addr u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_stride(slot_stride_q),
		.cpu_base   (cpu_base_q),
		.gpu_base   (gpu_base_q),
		.s1_valid   (s1_valid),
		.s1_ctl     (s1_ctl),
		.s1_index   (s1_index),
		.mem_rdata  (mem_rdata),
		.s1_ready   (s1_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the free-list slot allocator: driven streams, predicted results.
`timescale 1ns / 1ps
module tb_top;
	import fflsa_pkg::*;

	localparam int SLOT_CAP = 1024;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_PRINTS = 100;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		status_t     status;
		logic [9:0]  grant;
		logic [63:0] cpu_addr;
		logic [63:0] gpu_addr;
	} slot_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;

	// Shadow copy of the allocator configuration and queue state.
	logic [10:0]  count_reg = 11'd1024;
	logic [12:0]  stride_reg = 13'd32;
	logic [63:0]  cpu_base_reg = '0;
	logic [63:0]  gpu_base_reg = '0;
	int           fresh_next = 0;
	logic [9:0]   freed_q[$];

	slot_result_t pending_results[$];
	int           error_count = 0;
	int           idle_cycles = 0;
	int           hold_left = 0;
	bit           steady_flow = 1'b0;

	fifo_free_list_slot_allocator #(.MAX_SLOTS(SLOT_CAP)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		if (error_count < MAX_PRINTS) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
		error_count++;
	endtask

	function automatic logic [63:0] slot_offset(input logic [9:0] idx);
		return {54'd0, idx} * {51'd0, stride_reg};
	endfunction

	// Works out the result of one accepted command and advances the shadow state.
	function automatic slot_result_t grant_or_release(input logic [1:0] kind,
			input logic [9:0] idx);
		slot_result_t r;
		int live;
		logic [9:0] g;
		live = (count_reg > SLOT_CAP) ? SLOT_CAP : int'(count_reg);
		r.status = ST_OK;
		r.grant = '0;
		r.cpu_addr = '0;
		r.gpu_addr = '0;
		case (kind)
			KIND_ALLOC: begin
				if (fresh_next < live) begin
					g = fresh_next[9:0];
					fresh_next++;
				end else if (freed_q.size() > 0) begin
					g = freed_q.pop_front();
				end else begin
					r.status = ST_EMPTY;
					return r;
				end
				r.grant = g;
				r.cpu_addr = cpu_base_reg + slot_offset(g);
				r.gpu_addr = gpu_base_reg + slot_offset(g);
			end
			KIND_FREE: begin
				if (int'(idx) >= live) begin
					r.status = ST_RANGE;
				end else if (freed_q.size() >= SLOT_CAP) begin
					r.status = ST_OVERFLOW;
				end else begin
					freed_q.push_back(idx);
				end
			end
			KIND_HANDLE: begin
				r.cpu_addr = cpu_base_reg + slot_offset(idx);
				r.gpu_addr = gpu_base_reg + slot_offset(idx);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_cmd(input logic [1:0] kind, input logic [9:0] idx);
		int gap;
		int pick;
		gap = 0;
		if (!steady_flow) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) gap = 0;
			else if (pick < 90) gap = $urandom_range(1, 3);
			else gap = $urandom_range(8, 30);
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'd0, idx};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(grant_or_release(kind, idx));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] reg_idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (reg_idx)
			CFG_SLOT_COUNT:  count_reg = value[10:0];
			CFG_SLOT_STRIDE: stride_reg = value[12:0];
			CFG_CPU_BASE:    cpu_base_reg = value;
			CFG_GPU_BASE:    gpu_base_reg = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Default registers: first fresh grants, addresses of extreme slots, unused kind, frees at both ends.
	task automatic test_reset_state();
		repeat (3) send_cmd(KIND_ALLOC, 10'h3FF);
		send_cmd(KIND_UNUSED, 10'h3FF);
		send_cmd(KIND_HANDLE, 10'h3FF);
		send_cmd(KIND_HANDLE, 10'h000);
		send_cmd(KIND_FREE, 10'h3FF);
		send_cmd(KIND_FREE, 10'h000);
	endtask

	// Small count with fresh indices used up, a stride of 4096 and a CPU base that wraps.
	task automatic test_limits_and_wrap();
		wait_idle();
		write_reg(CFG_SLOT_COUNT, 64'd2);
		write_reg(CFG_SLOT_STRIDE, 64'd4096);
		write_reg(CFG_CPU_BASE, {64{1'b1}});
		write_reg(CFG_GPU_BASE, 64'h8000_0000_0000_0000);
		send_cmd(KIND_FREE, 10'd2);
		send_cmd(KIND_FREE, 10'h3FF);
		send_cmd(KIND_ALLOC, 10'd0);
		send_cmd(KIND_ALLOC, 10'd0);
		send_cmd(KIND_ALLOC, 10'd0);
		send_cmd(KIND_HANDLE, 10'h3FF);
		send_cmd(KIND_FREE, 10'd1);
		send_cmd(KIND_ALLOC, 10'h2AA);
	endtask

	// A count of zero has no slots; a count above capacity is clamped.
	task automatic test_zero_and_oversize_count();
		wait_idle();
		write_reg(CFG_SLOT_COUNT, 64'd0);
		send_cmd(KIND_ALLOC, 10'd0);
		send_cmd(KIND_FREE, 10'd0);
		wait_idle();
		write_reg(CFG_SLOT_COUNT, 64'h7FF);
		write_reg(CFG_SLOT_STRIDE, 64'd1);
		send_cmd(KIND_ALLOC, 10'd0);
		send_cmd(KIND_HANDLE, 10'd5);
		send_cmd(KIND_FREE, 10'h3FF);
	endtask

	// Fill the freed-index queue to capacity, push past it, then pull from it.
	task automatic test_free_list_overflow();
		wait_idle();
		write_reg(CFG_SLOT_COUNT, 64'(SLOT_CAP));
		write_reg(CFG_SLOT_STRIDE, 64'($urandom_range(0, 8191)));
		write_reg(CFG_CPU_BASE, {$urandom(), $urandom()});
		write_reg(CFG_GPU_BASE, {$urandom(), $urandom()});
		while (freed_q.size() < SLOT_CAP) send_cmd(KIND_FREE, 10'($urandom_range(0, 1023)));
		repeat (3) send_cmd(KIND_FREE, 10'($urandom_range(0, 1023)));
		wait_idle();
		// With fresh indices already spent, every grant now comes from the queue.
		write_reg(CFG_SLOT_COUNT, 64'd1);
		repeat (200) begin
			if ($urandom_range(0, 9) == 0) send_cmd(KIND_HANDLE, 10'($urandom_range(0, 1023)));
			else send_cmd(KIND_ALLOC, 10'($urandom_range(0, 1023)));
		end
	endtask

	task automatic test_random_mix();
		int phase;
		int pick;
		int live;
		logic [10:0] new_count;
		logic [12:0] new_stride;
		logic [9:0] idx;
		for (phase = 0; phase < 8; phase++) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0: new_count = 11'd0;
				1: new_count = 11'd1;
				2: new_count = 11'(SLOT_CAP);
				3: new_count = 11'h7FF;
				4: new_count = 11'($urandom_range(1, 64));
				default: new_count = 11'($urandom_range(1, 2047));
			endcase
			case ($urandom_range(0, 3))
				0: new_stride = 13'd1;
				1: new_stride = 13'd4096;
				2: new_stride = 13'h1FFF;
				default: new_stride = 13'($urandom_range(0, 8191));
			endcase
			write_reg(CFG_SLOT_COUNT, {53'd0, new_count});
			write_reg(CFG_SLOT_STRIDE, {51'd0, new_stride});
			write_reg(CFG_CPU_BASE, ($urandom_range(0, 3) == 0) ? {64{1'b1}}
				: {$urandom(), $urandom()});
			write_reg(CFG_GPU_BASE, ($urandom_range(0, 3) == 0) ? {64{1'b1}}
				: {$urandom(), $urandom()});
			steady_flow = (phase == 3);
			live = (count_reg > SLOT_CAP) ? SLOT_CAP : int'(count_reg);
			repeat (80) begin
				pick = $urandom_range(0, 99);
				idx = 10'($urandom_range(0, 1023));
				if (pick < 40) begin
					send_cmd(KIND_ALLOC, idx);
				end else if (pick < 75) begin
					// Mostly valid frees, some out of range.
					if (live > 0 && $urandom_range(0, 6) != 0)
						idx = 10'($urandom_range(0, live - 1));
					send_cmd(KIND_FREE, idx);
				end else if (pick < 95) begin
					send_cmd(KIND_HANDLE, idx);
				end else begin
					send_cmd(KIND_UNUSED, idx);
				end
			end
			steady_flow = 1'b0;
		end
	endtask

	// Result receiver with random stalls, short runs mostly and a few long ones; always ready in steady flow.
	always @(posedge clk) begin
		if (steady_flow) begin
			m_tready <= 1'b1;
			hold_left <= 0;
		end else if (hold_left == 0) begin
			if ($urandom_range(0, 99) < 60) begin
				m_tready <= 1'b1;
				hold_left <= $urandom_range(0, 4);
			end else begin
				m_tready <= 1'b0;
				hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
					: $urandom_range(0, 2);
			end
		end else begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		slot_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("result beat with nothing expected, status %0d", m_tuser));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status)
					report_error($sformatf("status %0d, expected %0d", m_tuser, want.status));
				if (m_tdata[9:0] !== want.grant)
					report_error($sformatf("granted_index %0d, expected %0d",
						m_tdata[9:0], want.grant));
				if (m_tdata[73:10] !== want.cpu_addr)
					report_error($sformatf("cpu_address %h, expected %h",
						m_tdata[73:10], want.cpu_addr));
				if (m_tdata[137:74] !== want.gpu_addr)
					report_error($sformatf("gpu_address %h, expected %h",
						m_tdata[137:74], want.gpu_addr));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_limits_and_wrap();
		test_zero_and_oversize_count();
		test_free_list_overflow();
		test_random_mix();
		wait_idle();
		if (pending_results.size() != 0)
			report_error($sformatf("%0d results never arrived", pending_results.size()));
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
